### rtl/core/tcsw_pkg.sv
// shared types, constants and helpers of the textured column span walker
package tcsw_pkg;

  // widest screen row index that any supported screen height needs
  localparam int ROW_W = 12;
  // quotient bits of the step divide, texture height (7 bits) shifted by 16
  localparam int DIV_BITS = 23;
  localparam int DEN_W = 17;
  localparam int ACC_W = 24;
  localparam int CFG_W = 7;

  localparam logic [0:0] CFG_TEX_WIDTH = 1'b0;
  localparam logic [0:0] CFG_TEX_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_DIV,
    BK_MUL
  } back_state_t;

  typedef struct packed {
    op_t              op;
    logic [11:0]      texel_index;
    logic [31:0]      texel_value;
    logic [9:0]       column;
    logic [ROW_W-1:0] row_start;
    logic [ROW_W-1:0] row_end;
    logic [15:0]      neg_first;
    logic [DEN_W-1:0] span_len;
    logic [5:0]       tex_column;
    logic             shade;
    logic             empty;
  } cmd_t;

  typedef struct packed {
    logic        valid;
    cmd_t        head;
  } cmd_q_t;

  typedef struct packed {
    logic [18:0] pixel_index;
    logic [31:0] pixel_value;
    logic        span_last;
  } out_t;

  // c * 3 >> 2 on each color byte, alpha untouched
  function automatic logic [31:0] shade_word(input logic [31:0] w);
    logic [9:0]  s;
    logic [31:0] r;
    begin
      r[31:24] = w[31:24];
      for (int i = 0; i < 3; i++) begin
        s = {1'b0, w[8*i +: 8], 1'b0} + {2'b00, w[8*i +: 8]};
        r[8*i +: 8] = s[9:2];
      end
      return r;
    end
  endfunction

endpackage

### rtl/core/tcsw_in_if.sv
// input channel: valid, ready and the item fields
interface tcsw_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [11:0]        texel_index;
  logic [31:0]        texel_value;
  logic [9:0]         column_x;
  logic signed [15:0] row_first;
  logic signed [15:0] row_final;
  logic [5:0]         tex_column;
  logic               shade_side;

  modport source(output valid, operation, texel_index, texel_value, column_x, row_first,
                 row_final, tex_column, shade_side, input ready);
  modport sink(input valid, operation, texel_index, texel_value, column_x, row_first,
               row_final, tex_column, shade_side, output ready);
endinterface

### rtl/core/tcsw_out_if.sv
// result channel: valid, ready and the pixel fields
interface tcsw_out_if;
  logic        valid;
  logic        ready;
  logic [18:0] pixel_index;
  logic [31:0] pixel_value;
  logic        span_last;

  modport source(output valid, pixel_index, pixel_value, span_last, input ready);
  modport sink(input valid, pixel_index, pixel_value, span_last, output ready);
endinterface

### rtl/core/tcsw_ram.sv
// generic single write port ram with registered read
module tcsw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/tcsw_cmd_q.sv
// two entry command queue between front and back
module tcsw_cmd_q
  import tcsw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  input  logic pop,
  output cmd_t dout,
  output logic full,
  output logic not_empty
);

  cmd_t       ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= din;
    end
  end

  assign dout      = ent_r[rd_ptr_r];
  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);

endmodule

### rtl/core/tcsw_div.sv
// restoring divider, one quotient bit per cycle
module tcsw_div
  import tcsw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DIV_BITS-1:0] num,
  input  logic [DEN_W-1:0]    den,
  output logic                done,
  output logic [DIV_BITS-1:0] quot
);

  localparam int CNT_W = $clog2(DIV_BITS);

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [DEN_W-1:0]    rem_r;
  logic [DIV_BITS-1:0] quo_r;
  logic [DEN_W-1:0]    den_r;
  logic [DEN_W:0]      rem_sh;
  logic                fits;
  logic [DEN_W:0]      rem_nxt;
  logic [DIV_BITS-1:0] quo_nxt;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_BITS-1]};
    fits    = (rem_sh >= {1'b0, den_r});
    rem_nxt = fits ? (rem_sh - {1'b0, den_r}) : rem_sh;
    quo_nxt = {quo_r[DIV_BITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder stays below the divisor, so its top bit is always clear
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt[DEN_W-1:0];
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

### rtl/core/tcsw_front.sv
// front: accepts items, clips span rows and queues commands
module tcsw_front
  import tcsw_pkg::*;
#(
  parameter int SCREEN_HEIGHT = 512,
  parameter int TEXTURE_WORDS = 4096
) (
  tcsw_in_if.sink in_ch,
  input  logic    q_full,
  output logic    push,
  output cmd_t    cmd
);

  logic signed [17:0] first_s;
  logic signed [17:0] last_s;
  logic signed [17:0] len_s;
  logic signed [17:0] first_c;
  logic signed [17:0] last_c;
  logic               len_pos;
  logic               load_in_range;
  logic [16:0]        idx_ext;
  op_t                op;

  assign in_ch.ready = !q_full;

  always_comb begin
    op       = op_t'(in_ch.operation);
    first_s  = 18'(in_ch.row_first);
    last_s   = 18'(in_ch.row_final);
    len_s    = last_s - first_s + 18'sd1;
    len_pos  = !len_s[17] && (len_s != 18'sd0);
    first_c  = first_s[17] ? 18'sd0 : first_s;
    last_c   = (last_s >= $signed(18'(SCREEN_HEIGHT))) ?
               $signed(18'(SCREEN_HEIGHT - 1)) : last_s;
    idx_ext  = {5'd0, in_ch.texel_index};
    load_in_range = (idx_ext < 17'(TEXTURE_WORDS));

    cmd.op          = op;
    cmd.texel_index = in_ch.texel_index;
    cmd.texel_value = in_ch.texel_value;
    cmd.column      = in_ch.column_x;
    cmd.row_start   = first_c[ROW_W-1:0];
    cmd.row_end     = last_c[ROW_W-1:0];
    cmd.neg_first   = first_s[17] ? 16'(-in_ch.row_first) : 16'd0;
    cmd.span_len    = len_s[DEN_W-1:0];
    cmd.tex_column  = in_ch.tex_column;
    cmd.shade       = in_ch.shade_side;
    cmd.empty       = !len_pos || (last_c < first_c);
  end

  // unknown codes and loads beyond the store never reach the queue
  always_comb begin
    push = 1'b0;
    if (in_ch.valid && !q_full) begin
      case (op)
        OP_LOAD:  push = load_in_range;
        OP_START: push = 1'b1;
        OP_STEP:  push = 1'b1;
        default:  push = 1'b0;
      endcase
    end
  end

endmodule

### rtl/core/tcsw_back.sv
// back: texture store, span state, step divide and pixel output
module tcsw_back
  import tcsw_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int TEXTURE_WORDS = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CFG_W-1:0] tex_width,
  input  logic [CFG_W-1:0] tex_height,
  input  cmd_q_t           q_in,
  output logic             q_pop,
  tcsw_out_if.source       out_ch
);

  localparam int AW = $clog2(TEXTURE_WORDS);

  back_state_t state_r, state_nxt;

  logic             span_active_r;
  logic [ROW_W-1:0] cur_row_r;
  logic [ROW_W-1:0] end_row_r;
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] step_r;
  logic [9:0]       col_r;
  logic [5:0]       tcol_r;
  logic             shade_r;

  logic             ram_we;
  logic             issue;
  logic             div_start;
  logic             span_load;
  logic             span_kill;
  logic             div_done;
  logic [DIV_BITS-1:0] quot;
  logic [38:0]      clip_prod;

  logic [16:0]      waddr_ext;
  logic [16:0]      raddr_ext;
  logic [31:0]      rdata;
  logic [24:0]      pix_full;

  logic             inflight_r;
  logic [18:0]      pix_q_r;
  logic             last_q_r;
  logic             shade_q_r;

  out_t             obuf_r [2];
  logic             owr_r;
  logic             ord_r;
  logic [1:0]       ocnt_r;
  logic             opop;
  logic             room;
  logic [2:0]       occ;

  cmd_t             head;

  assign head = q_in.head;

  // output buffer occupancy counting the read in flight
  assign opop = out_ch.valid && out_ch.ready;
  assign occ  = {1'b0, ocnt_r} + {2'b00, inflight_r} - {2'b00, opop};
  assign room = (occ < 3'd2);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_RUN: begin
        if (q_in.valid && head.op == OP_START && !head.empty) begin
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_done) begin
          state_nxt = BK_MUL;
        end
      end
      BK_MUL:  state_nxt = BK_RUN;
      default: state_nxt = BK_RUN;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    issue     = 1'b0;
    div_start = 1'b0;
    span_load = 1'b0;
    span_kill = 1'b0;
    case (state_r)
      BK_RUN: begin
        if (q_in.valid) begin
          case (head.op)
            OP_LOAD: begin
              ram_we = 1'b1;
              q_pop  = 1'b1;
            end
            OP_START: begin
              if (head.empty) begin
                span_kill = 1'b1;
                q_pop     = 1'b1;
              end else begin
                div_start = 1'b1;
              end
            end
            OP_STEP: begin
              if (!span_active_r) begin
                q_pop = 1'b1;
              end else if (room) begin
                issue = 1'b1;
                q_pop = 1'b1;
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      BK_MUL: begin
        span_load = 1'b1;
        q_pop     = 1'b1;
      end
      default: ;
    endcase
  end

  tcsw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({tex_height, 16'd0}),
    .den   (head.span_len),
    .done  (div_done),
    .quot  (quot)
  );

  // texture row offset of the rows clipped above the screen
  assign clip_prod = {23'd0, head.neg_first} * {16'd0, quot};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= BK_RUN;
      span_active_r <= 1'b0;
      cur_row_r     <= '0;
      end_row_r     <= '0;
      acc_r         <= '0;
      step_r        <= '0;
      col_r         <= '0;
      tcol_r        <= '0;
      shade_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (span_load) begin
        span_active_r <= 1'b1;
        cur_row_r     <= head.row_start;
        end_row_r     <= head.row_end;
        acc_r         <= clip_prod[ACC_W-1:0];
        step_r        <= {1'b0, quot};
        col_r         <= head.column;
        tcol_r        <= head.tex_column;
        shade_r       <= head.shade;
      end else if (span_kill) begin
        span_active_r <= 1'b0;
      end else if (issue) begin
        if (cur_row_r == end_row_r) begin
          span_active_r <= 1'b0;
        end else begin
          cur_row_r <= cur_row_r + 1'b1;
        end
        acc_r <= acc_r + step_r;
      end
    end
  end

  // store address wraps at the store size
  assign waddr_ext = {5'd0, head.texel_index};
  assign raddr_ext = {9'd0, acc_r[ACC_W-1:16]} * {10'd0, tex_width} + {11'd0, tcol_r};
  assign pix_full  = 25'(cur_row_r) * 25'(SCREEN_WIDTH) + 25'(col_r);

  tcsw_ram #(
    .WIDTH (32),
    .DEPTH (TEXTURE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr_ext[AW-1:0]),
    .wdata (head.texel_value),
    .raddr (raddr_ext[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= 1'b0;
    end else begin
      inflight_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pix_q_r   <= pix_full[18:0];
      last_q_r  <= (cur_row_r == end_row_r);
      shade_q_r <= shade_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= 1'b0;
      ord_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (inflight_r) begin
        owr_r <= ~owr_r;
      end
      if (opop) begin
        ord_r <= ~ord_r;
      end
      ocnt_r <= ocnt_r + {1'b0, inflight_r} - {1'b0, opop};
    end
  end

  always_ff @(posedge clk) begin
    if (inflight_r) begin
      obuf_r[owr_r].pixel_index <= pix_q_r;
      obuf_r[owr_r].pixel_value <= shade_q_r ? shade_word(rdata) : rdata;
      obuf_r[owr_r].span_last   <= last_q_r;
    end
  end

  assign out_ch.valid       = (ocnt_r != 2'd0);
  assign out_ch.pixel_index = obuf_r[ord_r].pixel_index;
  assign out_ch.pixel_value = obuf_r[ord_r].pixel_value;
  assign out_ch.span_last   = obuf_r[ord_r].span_last;

`ifndef NO_ASSERTIONS
  a_obuf_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (ocnt_r == 2'd2 && inflight_r) |-> opop)
    else $error("output buffer overflow");

  a_row_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    span_active_r |-> (cur_row_r <= end_row_r))
    else $error("span row past its end");

  a_store_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == BK_RUN && !issue))
    else $error("texture write during span setup");

  a_div_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV && div_done) |=> (state_r == BK_MUL && q_pop))
    else $error("span setup skipped after divide");
`endif

endmodule

### rtl/core/textured_column_span_walker.sv
// top level: config registers, front classifier, command queue and back end
// step transaction: one pixel per cycle sustained while the output buffer has room
// start transaction: a non-empty span holds the back end for a 23-step restoring divide
// load transaction: written from the back end through one texture store write port
// rst_n is synchronous active low: clears queues, span state and config to 64
// the texture store is not cleared on reset; its size must be a power of two
module textured_column_span_walker
  import tcsw_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 512,
  parameter int TEXTURE_WORDS = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  tcsw_in_if.sink          in_ch,
  tcsw_out_if.source       out_ch
);

  // texture geometry registers
  logic [CFG_W-1:0] tex_width_r;
  logic [CFG_W-1:0] tex_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= CFG_W'(64);
      tex_height_r <= CFG_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEX_WIDTH:  tex_width_r  <= cfg_wdata;
        CFG_TEX_HEIGHT: tex_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front to queue
  logic   q_full;
  logic   q_push;
  logic   q_pop;
  logic   q_valid;
  cmd_t   q_din;
  cmd_t   q_head;
  cmd_q_t q_bus;

  tcsw_front #(
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .TEXTURE_WORDS (TEXTURE_WORDS)
  ) u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (q_push),
    .cmd    (q_din)
  );

  // decouples the input handshake from divides and output stalls
  tcsw_cmd_q u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din       (q_din),
    .pop       (q_pop),
    .dout      (q_head),
    .full      (q_full),
    .not_empty (q_valid)
  );

  // queue head as the back end sees it
  assign q_bus = '{valid: q_valid, head: q_head};

  tcsw_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .TEXTURE_WORDS (TEXTURE_WORDS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .tex_width  (tex_width_r),
    .tex_height (tex_height_r),
    .q_in       (q_bus),
    .q_pop      (q_pop),
    .out_ch     (out_ch)
  );

endmodule
